// File: sv/agpc_pkg.sv
// Shared types, constants and the control store for the adaptive gain PWM controller.
// Used by agpc_regs and adaptive_gain_pwm_controller; depends on nothing else.
package agpc_pkg;

  localparam int unsigned AdcBits   = 10;
  localparam int unsigned SampleW   = 10;
  localparam int unsigned CompareW  = 16;
  localparam int unsigned RefW      = 10;
  localparam int unsigned DividendW = SampleW + RefW;
  localparam int unsigned ProdW     = 2 * CompareW;
  localparam int unsigned ScaledW   = ProdW - AdcBits;
  localparam int unsigned DivCntW   = $clog2(DividendW + 1);
  localparam int unsigned UpcW      = 4;
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned PdataW    = 32;

  // command codes
  localparam logic [1:0] CmdEnvelope = 2'd0;
  localparam logic [1:0] CmdInput    = 2'd1;
  localparam logic [1:0] CmdTick     = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] RegRefAmp    = 2'd0;
  localparam logic [1:0] RegThreshold = 2'd1;
  localparam logic [1:0] RegPeriod    = 2'd2;
  localparam logic [1:0] RegLedOn     = 2'd3;

  localparam logic [RefW-1:0]     RefAmpReset    = RefW'(465);
  localparam logic [SampleW-1:0]  ThresholdReset = SampleW'(62);
  localparam logic [CompareW-1:0] PeriodReset    = CompareW'(66);
  localparam logic [CompareW-1:0] LedOnReset     = CompareW'(5);

  typedef struct packed {
    logic [1:0]         command;
    logic [SampleW-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CompareW-1:0] pwm_compare;
    logic [CompareW-1:0] pending_compare;
    logic [CompareW-1:0] led_compare;
    logic                fault;
  } out_item_t;

  typedef struct packed {
    logic [RefW-1:0]     reference_amplitude;
    logic [SampleW-1:0]  min_envelope;
    logic [CompareW-1:0] period_ticks;
    logic [CompareW-1:0] led_on_time;
  } cfg_t;

  // microcode addresses
  localparam logic [UpcW-1:0] UpcIdle     = 4'd0;
  localparam logic [UpcW-1:0] UpcDispatch = 4'd1;
  localparam logic [UpcW-1:0] UpcEnv      = 4'd2;
  localparam logic [UpcW-1:0] UpcInp      = 4'd3;
  localparam logic [UpcW-1:0] UpcTick     = 4'd4;
  localparam logic [UpcW-1:0] UpcCheck    = 4'd5;
  localparam logic [UpcW-1:0] UpcCompute  = 4'd6;
  localparam logic [UpcW-1:0] UpcMulGain  = 4'd7;
  localparam logic [UpcW-1:0] UpcDiv      = 4'd8;
  localparam logic [UpcW-1:0] UpcSat      = 4'd9;
  localparam logic [UpcW-1:0] UpcPass     = 4'd10;
  localparam logic [UpcW-1:0] UpcMulPer   = 4'd11;
  localparam logic [UpcW-1:0] UpcScale    = 4'd12;
  localparam logic [UpcW-1:0] UpcDone     = 4'd13;

  typedef enum logic [3:0] {
    OP_NOP, OP_LATCH, OP_ENV, OP_INP, OP_TICK, OP_MULG,
    OP_DIV, OP_SAT, OP_PASS, OP_MULP, OP_SCALE, OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    HOLD_NONE, HOLD_ITEM, HOLD_OUT
  } hold_e;

  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_FAULT, COND_DIV_MORE, COND_DISPATCH
  } cond_e;

  typedef struct packed {
    op_e             op;
    hold_e           hold;
    cond_e           cond;
    logic [UpcW-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UpcW-1:0] upc);
    ucode_t w;
    w = '{op: OP_NOP, hold: HOLD_NONE, cond: COND_ALWAYS, target: UpcIdle};
    unique case (upc)
      UpcIdle:     w = '{op: OP_LATCH, hold: HOLD_ITEM, cond: COND_NEVER,    target: UpcIdle};
      UpcDispatch: w = '{op: OP_NOP,   hold: HOLD_NONE, cond: COND_DISPATCH, target: UpcIdle};
      UpcEnv:      w = '{op: OP_ENV,   hold: HOLD_NONE, cond: COND_ALWAYS,   target: UpcCheck};
      UpcInp:      w = '{op: OP_INP,   hold: HOLD_NONE, cond: COND_ALWAYS,   target: UpcCompute};
      UpcTick:     w = '{op: OP_TICK,  hold: HOLD_NONE, cond: COND_ALWAYS,   target: UpcDone};
      UpcCheck:    w = '{op: OP_NOP,   hold: HOLD_NONE, cond: COND_FAULT,    target: UpcDone};
      UpcCompute:  w = '{op: OP_NOP,   hold: HOLD_NONE, cond: COND_FAULT,    target: UpcPass};
      UpcMulGain:  w = '{op: OP_MULG,  hold: HOLD_NONE, cond: COND_NEVER,    target: UpcIdle};
      UpcDiv:      w = '{op: OP_DIV,   hold: HOLD_NONE, cond: COND_DIV_MORE, target: UpcDiv};
      UpcSat:      w = '{op: OP_SAT,   hold: HOLD_NONE, cond: COND_ALWAYS,   target: UpcMulPer};
      UpcPass:     w = '{op: OP_PASS,  hold: HOLD_NONE, cond: COND_NEVER,    target: UpcIdle};
      UpcMulPer:   w = '{op: OP_MULP,  hold: HOLD_NONE, cond: COND_NEVER,    target: UpcIdle};
      UpcScale:    w = '{op: OP_SCALE, hold: HOLD_NONE, cond: COND_NEVER,    target: UpcIdle};
      UpcDone:     w = '{op: OP_EMIT,  hold: HOLD_OUT,  cond: COND_ALWAYS,   target: UpcIdle};
      default:     w = '{op: OP_NOP,   hold: HOLD_NONE, cond: COND_ALWAYS,   target: UpcIdle};
    endcase
    return w;
  endfunction

endpackage

// File: sv/agpc_regs.sv
// APB register file for the adaptive gain PWM controller.
// Depends on agpc_pkg for the register map and the cfg_t bundle.
module agpc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [agpc_pkg::PaddrW-1:0]  paddr,
  input  logic [agpc_pkg::PdataW-1:0]  pwdata,
  output logic [agpc_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output agpc_pkg::cfg_t               cfg_o
);

  agpc_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reference_amplitude <= agpc_pkg::RefAmpReset;
      cfg_q.min_envelope        <= agpc_pkg::ThresholdReset;
      cfg_q.period_ticks        <= agpc_pkg::PeriodReset;
      cfg_q.led_on_time         <= agpc_pkg::LedOnReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        agpc_pkg::RegRefAmp:    cfg_q.reference_amplitude <= pwdata[agpc_pkg::RefW-1:0];
        agpc_pkg::RegThreshold: cfg_q.min_envelope <= pwdata[agpc_pkg::SampleW-1:0];
        agpc_pkg::RegPeriod:    cfg_q.period_ticks <= pwdata[agpc_pkg::CompareW-1:0];
        agpc_pkg::RegLedOn:     cfg_q.led_on_time <= pwdata[agpc_pkg::CompareW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      agpc_pkg::RegRefAmp:
        prdata = agpc_pkg::PdataW'(cfg_q.reference_amplitude);
      agpc_pkg::RegThreshold:
        prdata = agpc_pkg::PdataW'(cfg_q.min_envelope);
      agpc_pkg::RegPeriod:
        prdata = agpc_pkg::PdataW'(cfg_q.period_ticks);
      agpc_pkg::RegLedOn:
        prdata = agpc_pkg::PdataW'(cfg_q.led_on_time);
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/adaptive_gain_pwm_controller.sv
// Adaptive gain PWM controller top level: microcoded sequencer plus datapath.
// Depends on agpc_pkg (types, control store) and agpc_regs (APB registers).
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid_i, in_stall_o, in_data_i       | sink
//   out     | out_valid_o, out_stall_i, out_data_o    | source
//   cfg     | psel, penable, pwrite, paddr, pwdata,   | APB slave
//           | prdata, pready                          |
//
// One item at a time. An unknown command goes straight to the emit step; a tick updates
// the compares first; a faulting envelope is checked, then emitted; an input sample while
// faulted skips the divider and is scaled by the period; an input sample under gain and an
// envelope that clears the fault run the restoring divider (one quotient bit per cycle
// over 20 bits) before saturation and period scaling. The next beat is taken as soon as the
// sequencer is back at idle, while an earlier result may still sit in the output register.
// Reset is asynchronous and active low; no clearing pass. A stalled output holds
// the sequencer at its emit step only.
module adaptive_gain_pwm_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  agpc_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output agpc_pkg::out_item_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [agpc_pkg::PaddrW-1:0]  paddr,
  input  logic [agpc_pkg::PdataW-1:0]  pwdata,
  output logic [agpc_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);

  agpc_pkg::cfg_t cfg;

  agpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  logic [agpc_pkg::UpcW-1:0] upc_q, upc_d;
  agpc_pkg::ucode_t          uw;
  logic                      hold_ok;
  logic                      cond_ok;
  logic [agpc_pkg::UpcW-1:0] dispatch_upc;
  logic                      accept;

  // state and datapath
  logic [1:0]                          cmd_q;
  logic [agpc_pkg::SampleW-1:0]        sample_q;
  logic [agpc_pkg::SampleW-1:0]        envelope_q;
  logic                                fault_q;
  logic [agpc_pkg::SampleW-1:0]        last_q;
  logic [agpc_pkg::CompareW-1:0]       next_q;
  logic [agpc_pkg::CompareW-1:0]       active_q;
  logic [agpc_pkg::CompareW-1:0]       led_q;
  logic [agpc_pkg::DividendW-1:0]      dvd_q;
  logic [agpc_pkg::SampleW-1:0]        rem_q;
  logic [agpc_pkg::DivCntW-1:0]        div_cnt_q;
  logic [agpc_pkg::CompareW-1:0]       amp_q;
  logic [agpc_pkg::ProdW-1:0]          prod_q;
  logic [agpc_pkg::SampleW:0]          rem_shift;
  logic [agpc_pkg::SampleW:0]          rem_sub;
  logic                                qbit;
  logic [agpc_pkg::ScaledW-1:0]        scaled;
  logic                                scaled_over;

  logic                      out_valid_q;
  agpc_pkg::out_item_t       out_q;
  logic                      out_free;

  assign uw       = agpc_pkg::ucode_rom(upc_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = (upc_q == agpc_pkg::UpcIdle) && in_valid_i;

  always_comb begin
    unique case (cmd_q)
      agpc_pkg::CmdEnvelope: dispatch_upc = agpc_pkg::UpcEnv;
      agpc_pkg::CmdInput:    dispatch_upc = agpc_pkg::UpcInp;
      agpc_pkg::CmdTick:     dispatch_upc = agpc_pkg::UpcTick;
      default:               dispatch_upc = agpc_pkg::UpcDone;
    endcase
  end

  always_comb begin
    unique case (uw.hold)
      agpc_pkg::HOLD_NONE: hold_ok = 1'b1;
      agpc_pkg::HOLD_ITEM: hold_ok = in_valid_i;
      agpc_pkg::HOLD_OUT:  hold_ok = out_free;
      default:             hold_ok = 1'b1;
    endcase
    unique case (uw.cond)
      agpc_pkg::COND_NEVER:    cond_ok = 1'b0;
      agpc_pkg::COND_ALWAYS:   cond_ok = 1'b1;
      agpc_pkg::COND_FAULT:    cond_ok = fault_q;
      agpc_pkg::COND_DIV_MORE: cond_ok = (div_cnt_q != agpc_pkg::DivCntW'(1));
      agpc_pkg::COND_DISPATCH: cond_ok = 1'b1;
      default:                 cond_ok = 1'b0;
    endcase
    if (!hold_ok) begin
      upc_d = upc_q;
    end else if (cond_ok) begin
      upc_d = (uw.cond == agpc_pkg::COND_DISPATCH) ? dispatch_upc : uw.target;
    end else begin
      upc_d = upc_q + agpc_pkg::UpcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= agpc_pkg::UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  // restoring divide step: remainder stays below the envelope
  assign rem_shift = {rem_q, dvd_q[agpc_pkg::DividendW-1]};
  assign rem_sub   = rem_shift - {1'b0, envelope_q};
  assign qbit      = (rem_shift >= {1'b0, envelope_q});

  assign scaled      = prod_q[agpc_pkg::ProdW-1:agpc_pkg::AdcBits];
  assign scaled_over = scaled > agpc_pkg::ScaledW'(cfg.period_ticks);

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      envelope_q <= '0;
      fault_q    <= 1'b1;
      last_q     <= '0;
      next_q     <= '0;
      active_q   <= '0;
      led_q      <= '0;
    end else begin
      unique case (uw.op)
        agpc_pkg::OP_ENV: begin
          envelope_q <= sample_q;
          fault_q    <= (sample_q == '0) || (sample_q < cfg.min_envelope);
        end
        agpc_pkg::OP_INP: last_q <= sample_q;
        agpc_pkg::OP_TICK: begin
          active_q <= next_q;
          led_q    <= fault_q ? '0 : cfg.led_on_time;
        end
        agpc_pkg::OP_SCALE:
          next_q <= scaled_over ? cfg.period_ticks : scaled[agpc_pkg::CompareW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (uw.op == agpc_pkg::OP_MULG) begin
      div_cnt_q <= agpc_pkg::DivCntW'(agpc_pkg::DividendW);
    end else if (uw.op == agpc_pkg::OP_DIV) begin
      div_cnt_q <= div_cnt_q - agpc_pkg::DivCntW'(1);
    end
  end

  // datapath payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_data_i.command;
      sample_q <= in_data_i.sample;
    end
    unique case (uw.op)
      agpc_pkg::OP_MULG: begin
        dvd_q <= agpc_pkg::DividendW'(last_q) *
                 agpc_pkg::DividendW'(cfg.reference_amplitude);
        rem_q <= '0;
      end
      agpc_pkg::OP_DIV: begin
        dvd_q <= {dvd_q[agpc_pkg::DividendW-2:0], qbit};
        rem_q <= qbit ? rem_sub[agpc_pkg::SampleW-1:0] : rem_shift[agpc_pkg::SampleW-1:0];
      end
      agpc_pkg::OP_SAT:
        amp_q <= (|dvd_q[agpc_pkg::DividendW-1:agpc_pkg::CompareW]) ?
                 '1 : dvd_q[agpc_pkg::CompareW-1:0];
      agpc_pkg::OP_PASS: amp_q <= agpc_pkg::CompareW'(last_q);
      agpc_pkg::OP_MULP:
        prod_q <= agpc_pkg::ProdW'(cfg.period_ticks) * agpc_pkg::ProdW'(amp_q);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.op == agpc_pkg::OP_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.op == agpc_pkg::OP_EMIT && out_free) begin
      out_q.pwm_compare     <= active_q;
      out_q.pending_compare <= next_q;
      out_q.led_compare     <= led_q;
      out_q.fault           <= fault_q;
    end
  end

  assign in_stall_o  = (upc_q != agpc_pkg::UpcIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (upc_q == agpc_pkg::UpcDispatch))
    else $error("accepted beat not followed by dispatch");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == agpc_pkg::UpcDone && out_free) |=> (out_valid_q && upc_q == agpc_pkg::UpcIdle))
    else $error("emit step did not load output register");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == agpc_pkg::UpcDiv) |-> (div_cnt_q != '0))
    else $error("divider stepped with exhausted count");

  a_no_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fault_q |-> (envelope_q != '0))
    else $error("fault clear with zero envelope");

  a_div_from_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == agpc_pkg::UpcSat) |-> ($past(upc_q) == agpc_pkg::UpcDiv && !fault_q))
    else $error("saturation step reached outside gain path");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for adaptive_gain_pwm_controller: directed table, then random phases.
// Predicts result beats or takes typed-in ones; needs agpc_pkg and the controller RTL only.
module tb_top;
  import agpc_pkg::*;

  localparam logic [1:0]  CmdUnknown   = 2'd3;
  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 40;
  localparam int unsigned PhaseBeats   = 190;
  localparam int unsigned NumPhases    = 5;

  localparam out_item_t ResetView = {16'd0, 16'd0, 16'd0, 1'b1};

  typedef enum bit {RowBeat, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] wdata;
    in_item_t    beat;
    bit          known;
    out_item_t   want;
  } stim_row_t;

  // reset config first (ref 465, thr 62, period 66, led 5), then the extremes
  stim_row_t dir_tab [26] = '{
    '{RowBeat, RegRefAmp,    32'd0,     {CmdTick,     10'd0},    1'b1, ResetView},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdUnknown,  10'd1023}, 1'b1, ResetView},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdInput,    10'd1023}, 1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdEnvelope, 10'd0},    1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdEnvelope, 10'd61},   1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdTick,     10'd0},    1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdEnvelope, 10'd62},   1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdTick,     10'd1023}, 1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdEnvelope, 10'd1023}, 1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdInput,    10'd0},    1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdInput,    10'd512},  1'b0, '0},
    '{RowCfg,  RegRefAmp,    32'd1023,  '0,                      1'b0, '0},
    '{RowCfg,  RegThreshold, 32'd1,     '0,                      1'b0, '0},
    '{RowCfg,  RegPeriod,    32'd65535, '0,                      1'b0, '0},
    '{RowCfg,  RegLedOn,     32'd65535, '0,                      1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdEnvelope, 10'd1},    1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdInput,    10'd1023}, 1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdTick,     10'd0},    1'b0, '0},
    '{RowCfg,  RegThreshold, 32'd0,     '0,                      1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdEnvelope, 10'd0},    1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdTick,     10'd0},    1'b0, '0},
    '{RowCfg,  RegRefAmp,    32'd0,     '0,                      1'b0, '0},
    '{RowCfg,  RegPeriod,    32'd1,     '0,                      1'b0, '0},
    '{RowCfg,  RegLedOn,     32'd0,     '0,                      1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdEnvelope, 10'd700},  1'b0, '0},
    '{RowBeat, RegRefAmp,    32'd0,     {CmdInput,    10'd700},  1'b0, '0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr  = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic        pready;

  // sideband that travels with each beat: a typed-in expectation, if any
  logic        beat_known = 1'b0;
  out_item_t   beat_want  = '0;

  // shadow of the register file
  logic [9:0]  cfg_ref    = 10'd465;
  logic [9:0]  cfg_thr    = 10'd62;
  logic [15:0] cfg_period = 16'd66;
  logic [15:0] cfg_led    = 16'd5;

  // predicted controller state
  logic [9:0]  st_env    = '0;
  logic        st_fault  = 1'b1;
  logic [9:0]  st_last   = '0;
  logic [15:0] st_next   = '0;
  logic [15:0] st_active = '0;
  logic [15:0] st_led    = '0;

  out_item_t   ctrl_view_q[$];
  out_item_t   predicted;
  out_item_t   want;
  int unsigned beats_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;
  bit          hold_req      = 1'b0;

  adaptive_gain_pwm_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // pending compare from the last input sample under the current gain
  function automatic logic [15:0] gained_compare();
    logic [19:0] amp_full;
    logic [15:0] amp;
    logic [31:0] prod;
    logic [21:0] scaled;
    if (st_fault || st_env == 10'd0) begin
      amp_full = 20'(st_last);
    end else begin
      amp_full = (20'(st_last) * 20'(cfg_ref)) / 20'(st_env);
    end
    amp = (amp_full > 20'hFFFF) ? 16'hFFFF : amp_full[15:0];
    prod = 32'(cfg_period) * 32'(amp);
    scaled = prod[31:10];
    if (scaled > 22'(cfg_period)) return cfg_period;
    return scaled[15:0];
  endfunction

  function automatic out_item_t advance_controller(input in_item_t b);
    case (b.command)
      CmdEnvelope: begin
        st_env = b.sample;
        // zero envelope faults even with a zero threshold
        if (b.sample != 10'd0 && b.sample >= cfg_thr) begin
          st_fault = 1'b0;
          st_next  = gained_compare();
        end else begin
          st_fault = 1'b1;
        end
      end
      CmdInput: begin
        st_last = b.sample;
        st_next = gained_compare();
      end
      CmdTick: begin
        st_active = st_next;
        st_led    = st_fault ? 16'd0 : cfg_led;
      end
      default: ;
    endcase
    return {st_active, st_next, st_led, st_fault};
  endfunction

  function automatic in_item_t rand_beat();
    in_item_t    b;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) b.command = CmdUnknown;
    else if (r < 30) b.command = CmdEnvelope;
    else if (r < 76) b.command = CmdInput;
    else b.command = CmdTick;
    b.sample = 10'($urandom_range(1023));
    if (b.command == CmdEnvelope) begin
      case ($urandom_range(9))
        0: b.sample = '0;
        1: b.sample = cfg_thr;
        2: b.sample = cfg_thr - 10'd1;
        3, 4, 5, 6: b.sample = 10'($urandom_range(1023, 32'(cfg_thr)));
        default: ;
      endcase
    end
    return b;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endtask

  task automatic send_beat(input in_item_t b, input bit known, input out_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    beat_known <= known;
    beat_want  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_seen < beats_sent) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegRefAmp:    cfg_ref    = val[9:0];
      RegThreshold: cfg_thr    = val[9:0];
      RegPeriod:    cfg_period = val[15:0];
      RegLedOn:     cfg_led    = val[15:0];
      default: ;
    endcase
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // beat monitor and scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted = advance_controller(in_data_i);
        ctrl_view_q.push_back(beat_known ? beat_want : predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (ctrl_view_q.size() == 0) begin
          errors++;
          $error("result beat with no expectation pending");
        end else begin
          want = ctrl_view_q.pop_front();
          check_field("pwm_compare", want.pwm_compare, out_data_o.pwm_compare);
          check_field("pending_compare", want.pending_compare, out_data_o.pending_compare);
          check_field("led_compare", want.led_compare, out_data_o.led_compare);
          check_field("fault", 16'(want.fault), 16'(out_data_o.fault));
        end
      end
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] v_ref, v_thr, v_per, v_led;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowCfg) begin
        drain();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].wdata);
      end else begin
        send_beat(dir_tab[i].beat, dir_tab[i].known, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        1: begin
          v_ref = 32'd1023; v_thr = 32'd1; v_per = 32'd65535; v_led = 32'd65535;
        end
        2: begin
          v_ref = 32'd1; v_thr = 32'd1023; v_per = 32'd1; v_led = 32'd0;
        end
        default: begin
          v_ref = $urandom_range(1023, 1);
          v_thr = $urandom_range(400, 1);
          v_per = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : $urandom_range(2000, 1);
          v_led = $urandom_range(65535);
        end
      endcase
      write_reg(RegRefAmp, v_ref);
      write_reg(RegThreshold, v_thr);
      write_reg(RegPeriod, v_per);
      write_reg(RegLedOn, v_led);
      case (ph)
        1: begin send_idle_pct = 49; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 49; end
        3: begin send_idle_pct = 7; stall_pct = 7; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      // last phase: receiver holds off long enough for the block to back up
      if (ph == NumPhases - 1) hold_req = 1'b1;
      repeat (PhaseBeats) send_beat(rand_beat(), 1'b0, '0);
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (ctrl_view_q.size() != 0) begin
      errors++;
      $error("%0d expected result beats never arrived", ctrl_view_q.size());
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: adaptive_gain_pwm_controller.f
sv/agpc_pkg.sv
sv/agpc_regs.sv
sv/adaptive_gain_pwm_controller.sv
tb/sv/tb_top.sv
